// ===== sv/ms_pkg.sv =====
// ms_pkg: shared widths, field offsets, controller/datapath interface types
// and fixed-point helpers for the modal superposition block
// no dependencies
`default_nettype none

package ms_pkg;

	localparam int MAX_MODES = 64;
	localparam int MODE_W    = $clog2(MAX_MODES);
	localparam int VAL_W     = 32;
	localparam int ACC_W     = 48;
	localparam int TERM_W    = 48;
	localparam int CNT_W     = 16;
	localparam int STEP_W    = 16;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int FRAC_SH   = 30;
	localparam int SCL_W     = FRAC_SH + TERM_W;
	localparam int NPROD     = 6;
	localparam int SEL_W     = $clog2(NPROD);

	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'b1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TERM = 1'b1;

	// input word layout
	localparam int OFS_MODE   = 0;
	localparam int OFS_COORD  = OFS_MODE + MODE_W;
	localparam int OFS_RATE   = OFS_COORD + VAL_W;
	localparam int OFS_SHAPE  = OFS_RATE + VAL_W;
	localparam int OFS_BASE   = OFS_SHAPE + 3 * VAL_W;
	localparam int OFS_STEP   = OFS_BASE + 3 * VAL_W;
	localparam int IN_BITS    = OFS_STEP + STEP_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

	// output word layout
	localparam int OFS_PIDX    = 0;
	localparam int OFS_POS     = OFS_PIDX + CNT_W;
	localparam int OFS_VEL     = OFS_POS + 3 * ACC_W;
	localparam int OUT_BITS    = OFS_VEL + 3 * ACC_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic             capture;
		logic             store_we;
		logic             mul_en;
		logic [SEL_W-1:0] sel;
		logic             finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic step_ok;
		logic is_term;
		logic last;
		logic out_busy;
	} ctrl_sts_t;

	// saturate a sum one bit wider than the accumulator
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
		logic signed [ACC_W-1:0] r;
		if (s[ACC_W] != s[ACC_W-1])
			r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			r = s[ACC_W-1:0];
		return r;
	endfunction

	// p * 1000 with round half up, back to Q.15
	function automatic logic signed [TERM_W-1:0] scale_term(input logic signed [PROD_W-1:0] p);
		logic signed [SCL_W-1:0] e;
		logic signed [SCL_W-1:0] x;
		e = {{(SCL_W-PROD_W){p[PROD_W-1]}}, p};
		x = (e <<< 10) - (e <<< 4) - (e <<< 3) + (SCL_W'(1) <<< (FRAC_SH - 1));
		return x[FRAC_SH+TERM_W-1:FRAC_SH];
	endfunction

endpackage

`default_nettype wire

// ===== sv/ms_ctrl.sv =====
// ms_ctrl: sequencer for load and term words of the modal superposition block
// depends on ms_pkg
`default_nettype none

module ms_ctrl (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic in_valid,
	output logic               in_ready,
	input  wire ms_pkg::ctrl_sts_t sts,
	output ms_pkg::ctrl_cmd_t  cmd
);
	import ms_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_DRAIN1 = 3'd3;
	localparam logic [2:0] S_DRAIN2 = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [SEL_W-1:0] k_q, k_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		cmd          = '0;
		cmd.sel      = k_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				k_d = '0;
				if (!sts.step_ok) begin
					state_d = S_IDLE;
				end else if (!sts.is_term) begin
					cmd.store_we = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				if (k_q == SEL_W'(NPROD - 1)) begin
					state_d = S_DRAIN1;
				end else begin
					k_d = k_q + SEL_W'(1);
				end
			end
			S_DRAIN1: state_d = S_DRAIN2;
			S_DRAIN2: state_d = sts.last ? S_FINISH : S_IDLE;
			S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	a_capture_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_CHECK)
		else $error("capture not followed by check");
	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL && k_q == SEL_W'(NPROD - 1)) |=> state_q == S_DRAIN1)
		else $error("product sequence did not end after six products");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.out_busy && sts.last)
		else $error("finish while output word still held");
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_FINISH) |-> !in_ready)
		else $error("input taken while busy");

endmodule

`default_nettype wire

// ===== sv/ms_datapath.sv =====
// ms_datapath: modal stores, shared multiplier pipeline, accumulators,
// point counter, configuration registers and output register
// depends on ms_pkg
`default_nettype none

module ms_datapath (
	input  wire                logic                          clk,
	input  wire                logic                          arst_n,
	input  wire                logic                          cfg_we,
	input  wire                logic [ms_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire                logic [ms_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire                logic [ms_pkg::IN_TDATA_W-1:0] in_data,
	input  wire                logic                          in_user,
	input  wire                logic                          in_last,
	output logic                                              out_valid,
	input  wire                logic                          out_ready,
	output logic               [ms_pkg::OUT_TDATA_W-1:0]      out_data,
	output logic                                              out_last,
	input  wire ms_pkg::ctrl_cmd_t                            cmd,
	output ms_pkg::ctrl_sts_t                                 sts
);
	import ms_pkg::*;

	logic [CFG_W-1:0] step_count_q, point_count_q;
	logic [IN_BITS-1:0] in_q;
	logic               cmd_q, last_q;

	logic [VAL_W-1:0] coord_mem [MAX_MODES];
	logic [VAL_W-1:0] rate_mem  [MAX_MODES];
	logic [VAL_W-1:0] rd_coord_q, rd_rate_q;

	logic [MODE_W-1:0]       mode;
	logic signed [VAL_W-1:0] shape_x, shape_y, shape_z, base_x, base_y, base_z;
	logic [STEP_W-1:0]       tstep;
	logic signed [VAL_W-1:0] op_a, op_b;

	logic signed [PROD_W-1:0] p_s1;
	logic [SEL_W-1:0]         sel_s1, sel_s2;
	logic                     v_s1, v_s2;
	logic signed [TERM_W-1:0] term_s2;

	logic signed [ACC_W-1:0] acc_q [NPROD];
	logic signed [ACC_W-1:0] pos_x, pos_y, pos_z;
	logic [CNT_W-1:0]        pcnt_q;
	logic [CNT_W:0]          pcnt_inc;
	logic                    final_pt;

	assign mode    = in_q[OFS_MODE +: MODE_W];
	assign shape_x = in_q[OFS_SHAPE +: VAL_W];
	assign shape_y = in_q[OFS_SHAPE + VAL_W +: VAL_W];
	assign shape_z = in_q[OFS_SHAPE + 2 * VAL_W +: VAL_W];
	assign base_x  = in_q[OFS_BASE +: VAL_W];
	assign base_y  = in_q[OFS_BASE + VAL_W +: VAL_W];
	assign base_z  = in_q[OFS_BASE + 2 * VAL_W +: VAL_W];
	assign tstep   = in_q[OFS_STEP +: STEP_W];

	assign sts.step_ok  = !tstep[STEP_W-1] &&
		({1'b0, tstep[STEP_W-2:0]} < step_count_q);
	assign sts.is_term  = (cmd_q == CMD_TERM);
	assign sts.last     = last_q;
	assign sts.out_busy = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q  <= CFG_W'(1);
			point_count_q <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_STEP_COUNT:  step_count_q  <= cfg_wdata;
				REG_POINT_COUNT: point_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q   <= in_data[IN_BITS-1:0];
			cmd_q  <= in_user;
			last_q <= in_last;
		end
	end

	// modal stores
	always_ff @(posedge clk) begin
		if (cmd.store_we) begin
			coord_mem[mode] <= in_q[OFS_COORD +: VAL_W];
			rate_mem[mode]  <= in_q[OFS_RATE +: VAL_W];
		end
		rd_coord_q <= coord_mem[mode];
		rd_rate_q  <= rate_mem[mode];
	end

	always_comb begin
		case (cmd.sel)
			SEL_W'(0), SEL_W'(3): op_a = shape_x;
			SEL_W'(1), SEL_W'(4): op_a = shape_y;
			default:              op_a = shape_z;
		endcase
		op_b = (cmd.sel < SEL_W'(3)) ? $signed(rd_coord_q) : $signed(rd_rate_q);
	end

	// multiply, scale, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.mul_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1    <= op_a * op_b;
		sel_s1  <= cmd.sel;
		term_s2 <= scale_term(p_s1);
		sel_s2  <= sel_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPROD; i++) acc_q[i] <= '0;
		end else if (cmd.finish) begin
			for (int i = 0; i < NPROD; i++) acc_q[i] <= '0;
		end else if (v_s2) begin
			acc_q[sel_s2] <= sat_acc({acc_q[sel_s2][ACC_W-1], acc_q[sel_s2]} +
				{term_s2[TERM_W-1], term_s2});
		end
	end

	assign pos_x = sat_acc({acc_q[0][ACC_W-1], acc_q[0]} + (ACC_W+1)'(base_x));
	assign pos_y = sat_acc({acc_q[1][ACC_W-1], acc_q[1]} + (ACC_W+1)'(base_y));
	assign pos_z = sat_acc({acc_q[2][ACC_W-1], acc_q[2]} + (ACC_W+1)'(base_z));

	assign pcnt_inc = {1'b0, pcnt_q} + (CNT_W+1)'(1);
	assign final_pt = pcnt_inc >= {1'b0, point_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q    <= '0;
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			pcnt_q    <= final_pt ? '0 : pcnt_inc[CNT_W-1:0];
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data <= OUT_TDATA_W'({acc_q[5], acc_q[4], acc_q[3],
				pos_z, pos_y, pos_x, pcnt_q});
			out_last <= final_pt;
		end
	end

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> acc_q[0] == '0 && acc_q[3] == '0)
		else $error("accumulators not cleared after output");
	a_stage_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("scale stage valid without product");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !v_s1 && !v_s2)
		else $error("output taken while products still in flight");

endmodule

`default_nettype wire

// ===== sv/modal_superposition.sv =====
// Modal superposition: rebuilds position and velocity of mesh points from modal
// coordinates. A load word (tuser 0) stores coordinate and rate of one mode. A
// term word (tuser 1) runs through capture, store read, six products through one
// shared 32x32 multiplier, then scale and accumulate; with tlast set a finish
// step adds the base and fills the output register, waiting there only while a
// previous result is still held. Words outside the configured step range are
// captured and checked and do nothing.
// depends on ms_pkg, ms_ctrl, ms_datapath
`default_nettype none

module modal_superposition (
	input  wire  logic                           clk,
	input  wire  logic                           arst_n,
	input  wire  logic                           cfg_we,
	input  wire  logic [ms_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire  logic [ms_pkg::CFG_W-1:0]       cfg_wdata,
	input  wire  logic                           s_axis_tvalid,
	output logic                                 s_axis_tready,
	// mode_index, coord_value, coord_rate, shape_x, shape_y, shape_z,
	// base_x, base_y, base_z, time_step, zero pad
	input  wire  logic [ms_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// cmd
	input  wire  logic                           s_axis_tuser,
	// last_mode
	input  wire  logic                           s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  wire  logic                           m_axis_tready,
	// point_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	output logic       [ms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// last_point
	output logic                                 m_axis_tlast
);
	import ms_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	ms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ms_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// ===== tb/sv/modal_superposition_test.sv =====
// modal_superposition_test: self-checking stream testbench for modal_superposition
// predicts the six reconstructed sums per point and compares every output word
// depends on ms_pkg and modal_superposition
`timescale 1ns / 100ps

module modal_superposition_test;
	import ms_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam longint SAT_HI = 64'sh0000_7fff_ffff_ffff;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef struct packed {
		logic                        cmd;
		logic [MODE_W-1:0]           mode;
		logic [VAL_W-1:0]            coord;
		logic [VAL_W-1:0]            rate;
		logic [2:0][VAL_W-1:0]       shape;
		logic [2:0][VAL_W-1:0]       base;
		logic                        last;
		logic [STEP_W-1:0]           step;
	} sweep_word_t;

	typedef struct packed {
		logic [CNT_W-1:0]            point_index;
		logic [2:0][ACC_W-1:0]       pos;
		logic [2:0][ACC_W-1:0]       vel;
		logic                        last_point;
	} point_sums_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_addr = '0;
	logic [CFG_W-1:0]          cfg_wdata = '0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_TDATA_W-1:0]     s_axis_tdata = '0;
	logic                      s_axis_tuser = 1'b0;
	logic                      s_axis_tlast = 1'b0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]    m_axis_tdata;
	logic                      m_axis_tlast;

	// predictor state
	longint coord_mem [MAX_MODES];
	longint rate_mem [MAX_MODES];
	longint pos_acc [3];
	longint vel_acc [3];
	int     pt_cnt = 0;
	int     step_lim = 1;
	int     pt_lim = 1;

	sweep_word_t sweep_words [$];
	point_sums_t due_points [$];
	sweep_word_t offered;
	bit          mode_loaded [MAX_MODES];
	int          loaded_modes [$];

	int send_idle = 0;
	int recv_idle = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int cycle_count = 0;

	int step_tab [9] = '{65535, 0, 300, 1, 2, 40, 65535, 17, 1000};
	int pt_tab [9] = '{65535, 0, 0, 1, 2, 5, 7, 65535, 3};
	int len_tab [9] = '{150, 20, 130, 150, 150, 160, 150, 150, 150};

	modal_superposition dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint clamp48(input longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	// shape * value * 1000 in Q.15, round half up
	function automatic longint modal_term(input longint shp, input longint val);
		logic signed [79:0] e;
		e = shp * val;
		e = e * 80'sd1000 + (80'sd1 <<< 29);
		e = e >>> 30;
		return e[63:0];
	endfunction

	task automatic superpose_word(input sweep_word_t w);
		longint      shp;
		longint      pos;
		int          step;
		bit          wrap;
		point_sums_t r;
		step = int'($signed(w.step));
		if (step < 0 || step >= step_lim)
			return;
		if (w.cmd == CMD_LOAD) begin
			coord_mem[w.mode] = longint'($signed(w.coord));
			rate_mem[w.mode] = longint'($signed(w.rate));
			return;
		end
		for (int i = 0; i < 3; i++) begin
			shp = longint'($signed(w.shape[i]));
			pos_acc[i] = clamp48(pos_acc[i] + modal_term(shp, coord_mem[w.mode]));
			vel_acc[i] = clamp48(vel_acc[i] + modal_term(shp, rate_mem[w.mode]));
		end
		if (!w.last)
			return;
		wrap = (pt_cnt + 1) >= pt_lim;
		r.point_index = pt_cnt[CNT_W-1:0];
		for (int i = 0; i < 3; i++) begin
			pos = clamp48(pos_acc[i] + longint'($signed(w.base[i])));
			r.pos[i] = pos[ACC_W-1:0];
			r.vel[i] = vel_acc[i][ACC_W-1:0];
			pos_acc[i] = 0;
			vel_acc[i] = 0;
		end
		r.last_point = wrap;
		pt_cnt = wrap ? 0 : ((pt_cnt + 1) & 16'hffff);
		due_points.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %h, actual %h", name, want, got);
			errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic [IN_TDATA_W-1:0] data;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				superpose_word(offered);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (sweep_words.size() != 0 && $urandom_range(99) >= send_idle) begin
					offered = sweep_words.pop_front();
					data = '0;
					data[OFS_MODE +: MODE_W] = offered.mode;
					data[OFS_COORD +: VAL_W] = offered.coord;
					data[OFS_RATE +: VAL_W] = offered.rate;
					for (int i = 0; i < 3; i++) begin
						data[OFS_SHAPE + i * VAL_W +: VAL_W] = offered.shape[i];
						data[OFS_BASE + i * VAL_W +: VAL_W] = offered.base[i];
					end
					data[OFS_STEP +: STEP_W] = offered.step;
					s_axis_tdata <= data;
					s_axis_tuser <= offered.cmd;
					s_axis_tlast <= offered.last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		point_sums_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_points.size() == 0) begin
					$error("output word with no point result pending");
					errors++;
				end else begin
					want = due_points.pop_front();
					check_field("point_index", want.point_index, m_axis_tdata[OFS_PIDX +: CNT_W]);
					check_field("pos_x", want.pos[0], m_axis_tdata[OFS_POS +: ACC_W]);
					check_field("pos_y", want.pos[1], m_axis_tdata[OFS_POS + ACC_W +: ACC_W]);
					check_field("pos_z", want.pos[2], m_axis_tdata[OFS_POS + 2 * ACC_W +: ACC_W]);
					check_field("vel_x", want.vel[0], m_axis_tdata[OFS_VEL +: ACC_W]);
					check_field("vel_y", want.vel[1], m_axis_tdata[OFS_VEL + ACC_W +: ACC_W]);
					check_field("vel_z", want.vel[2], m_axis_tdata[OFS_VEL + 2 * ACC_W +: ACC_W]);
					check_field("last_point", want.last_point, m_axis_tlast);
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= $urandom_range(99) >= recv_idle;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [VAL_W-1:0] rand_val();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(255));
			3: return {{2{1'($urandom_range(1))}}, 30'($urandom())};
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] rand_step(input bit valid);
		int top;
		top = (step_lim > 32768) ? 32767 : step_lim - 1;
		if (valid)
			return ($urandom_range(3) == 0) ? 16'(top) : 16'($urandom_range(top));
		if (step_lim <= 32767 && $urandom_range(1) == 0)
			return ($urandom_range(1) == 0) ? 16'(step_lim) : 16'($urandom_range(32767, step_lim));
		return ($urandom_range(3) == 0) ? 16'hffff : (16'h8000 | 16'($urandom()));
	endfunction

	function automatic sweep_word_t rand_word();
		sweep_word_t w;
		bit          ok;
		ok = step_lim > 0 && $urandom_range(99) < 88;
		w.cmd = ($urandom_range(99) < 30) ? CMD_LOAD : CMD_TERM;
		if (ok && w.cmd == CMD_TERM && loaded_modes.size() == 0)
			w.cmd = CMD_LOAD;
		if (ok && w.cmd == CMD_TERM)
			w.mode = MODE_W'(loaded_modes[$urandom_range(loaded_modes.size() - 1)]);
		else
			w.mode = MODE_W'($urandom_range(MAX_MODES - 1));
		w.coord = rand_val();
		w.rate = rand_val();
		for (int i = 0; i < 3; i++) begin
			w.shape[i] = rand_val();
			w.base[i] = rand_val();
		end
		w.last = $urandom_range(99) < 22;
		w.step = rand_step(ok);
		return w;
	endfunction

	function automatic sweep_word_t mk_word(input logic cmd, input int mode,
			input logic [VAL_W-1:0] coord, input logic [VAL_W-1:0] rate,
			input logic [VAL_W-1:0] sx, input logic [VAL_W-1:0] sy,
			input logic [VAL_W-1:0] sz, input logic [VAL_W-1:0] bse,
			input logic last, input logic [STEP_W-1:0] step);
		sweep_word_t w;
		w.cmd = cmd;
		w.mode = MODE_W'(mode);
		w.coord = coord;
		w.rate = rate;
		w.shape[0] = sx;
		w.shape[1] = sy;
		w.shape[2] = sz;
		for (int i = 0; i < 3; i++)
			w.base[i] = bse;
		w.last = last;
		w.step = step;
		return w;
	endfunction

	task automatic push_word(input sweep_word_t w);
		int step;
		step = int'($signed(w.step));
		if (w.cmd == CMD_LOAD && step >= 0 && step < step_lim && !mode_loaded[w.mode]) begin
			mode_loaded[w.mode] = 1'b1;
			loaded_modes.push_back(int'(w.mode));
		end
		sweep_words.push_back(w);
	endtask

	// long run of extreme terms on one mode to drive the sums into saturation
	task automatic saturation_run(input bit neg);
		int               mode;
		logic [VAL_W-1:0] s;
		mode = $urandom_range(MAX_MODES - 1);
		s = neg ? 32'h8000_0000 : 32'h7fff_ffff;
		push_word(mk_word(CMD_LOAD, mode, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 1'b0,
			rand_step(1'b1)));
		for (int i = 0; i < 36; i++)
			push_word(mk_word(CMD_TERM, mode, 0, 0, s, s, s, s, i == 35, rand_step(1'b1)));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= CFG_W'(val);
		if (idx == REG_STEP_COUNT)
			step_lim = val & 16'hffff;
		else
			pt_lim = val & 16'hffff;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (sweep_words.size() != 0 || s_axis_tvalid || due_points.size() != 0);
		repeat (24) @(negedge clk);
	endtask

	initial begin
		for (int i = 0; i < 3; i++) begin
			pos_acc[i] = 0;
			vel_acc[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_idle = 36;
		recv_idle = 62;
		write_reg(REG_STEP_COUNT, 4);
		write_reg(REG_POINT_COUNT, 3);

		// directed: extremes, ignored steps, half-way rounding, point wrap
		push_word(mk_word(CMD_LOAD, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 1'b0, 16'd0));
		push_word(mk_word(CMD_LOAD, 63, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 1'b1, 16'd3));
		push_word(mk_word(CMD_LOAD, 1, 32'd1, 32'hffff_ffff, 0, 0, 0, 0, 1'b0, 16'd1));
		push_word(mk_word(CMD_LOAD, 2, 32'h0000_8000, 32'hffff_8000, 0, 0, 0, 0, 1'b0, 16'd2));
		push_word(mk_word(CMD_LOAD, 5, 32'd123, 32'd456, 0, 0, 0, 0, 1'b0, 16'd4));
		push_word(mk_word(CMD_LOAD, 6, 32'd7, 32'd9, 0, 0, 0, 0, 1'b0, 16'hffff));
		push_word(mk_word(CMD_TERM, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0,
			1'b0, 16'd0));
		push_word(mk_word(CMD_TERM, 63, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 1'b1, 16'd1));
		push_word(mk_word(CMD_TERM, 1, 0, 0, 32'h0400_0000, 32'hfc00_0000, 32'h0, 32'h8000_0000,
			1'b1, 16'd2));
		push_word(mk_word(CMD_TERM, 2, 0, 0, 32'h4000_0000, 32'hc000_0000, 32'h1, 32'h0,
			1'b1, 16'd3));
		push_word(mk_word(CMD_TERM, 0, 0, 0, 32'h1, 32'h1, 32'h1, 32'h1, 1'b1, 16'd4));
		push_word(mk_word(CMD_TERM, 5, 0, 0, 32'h1, 32'h1, 32'h1, 32'h1, 1'b1, 16'h8000));
		push_word(mk_word(CMD_TERM, 2, 0, 0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 1'b1, 16'd0));
		push_word(mk_word(CMD_TERM, 63, 0, 0, 32'h0000_0001, 32'h8000_0000, 32'h4000_0000, 0,
			1'b0, 16'd3));
		push_word(mk_word(CMD_TERM, 0, 0, 0, 32'hc000_0000, 32'h3fff_ffff, 32'hffff_ffff,
			32'h8000_0000, 1'b1, 16'd2));

		for (int k = 0; k < 9; k++) begin
			settle();
			if (k == 3) begin
				send_idle = 62;
				recv_idle = 36;
			end
			if (k == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_reg(REG_STEP_COUNT, step_tab[k]);
			write_reg(REG_POINT_COUNT, pt_tab[k]);
			for (int n = 0; n < len_tab[k]; n++)
				push_word(rand_word());
			if (k == 0 || k == 4 || k == 7)
				saturation_run(k == 7);
			if (k == 6)
				hold_req++;
		end
		settle();

		if (errors == 0 && due_points.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
